>>> src/nfps_pkg.sv
package nfps_pkg;

    // Default table depth
    localparam int MAX_SAMPLES_DEF = 256;

    // Datapath widths
    localparam int NUM_AXES = 3;
    localparam int COORD_W  = 16;
    localparam int PT_W     = NUM_AXES * COORD_W;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int SQ_W     = 2 * DELTA_W - 1;   // square of a 17-bit delta, unsigned
    localparam int PROD_W   = DELTA_W + COORD_W; // delta times Q1.15 normal, signed
    localparam int D2_W     = SQ_W + 1;          // sum of three squares
    localparam int DOT_W    = PROD_W + 2;        // sum of three products

    // Port widths
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;

    // Input tdata field positions
    localparam int POS_LSB     = 0;
    localparam int NORMAL_LSB  = PT_W;
    localparam int OUTLINE_BIT = 2 * PT_W;

    // Output tuser flag positions
    localparam int FOUND_BIT = 0;
    localparam int FULL_BIT  = 1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0]
    {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // One sample moving down the cell row with its partial sums
    typedef struct packed
    {
        logic                      valid;
        logic                      first;
        logic                      last;
        coord_t [NUM_AXES-1:0]     pt;
        logic [D2_W-1:0]           d2;
        logic signed [DOT_W-1:0]   dot;
    } beat_t;

endpackage

>>> src/nearest_facing_point_search.sv
// Nearest facing point search.
// Input stream (s_*): one beat is one command, clear, append or query, taken
// when s_tvalid and s_tready are both high. Output stream (m_*): exactly one
// result beat per command, in command order.
// Clear and append: the result moves from the pending to the output register.
// Query with an outline over N stored samples (N > 0): the table is read one
// entry per cycle through the single RAM read port, and each entry runs down a
// row of three axis cells (3 stages each) into the selector, and the result
// is set pending as the last entry leaves the row. A query without an
// outline, or on an empty table, answers through the pending and output registers.
// One command is in work at a time; s_tready drops from the command beat
// until its result has left the pending register for the output register,
// so a clear, an append or a query is not taken while the one before it is
// still in the sequencer or the pending register.
// One result may wait in
// the output register while the next command is taken and worked on.
// When the receiver stalls, the output beat holds and, once a second result is
// pending, s_tready stays low until m_tready returns.
// Reset empties the table (count to zero) and leaves no beat in flight; the
// sample RAM itself is not cleared, as only written entries are ever read.
module nearest_facing_point_search
    import nfps_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, has_outline, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // sample_index
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // found, table_full
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int IDXW = (AW > OUT_TDATA_W) ? AW : OUT_TDATA_W;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   scan_addr_reg, scan_addr_next;
    coord_t [NUM_AXES-1:0] center_reg, normal_reg;
    logic            latch_query;

    logic            issue_valid_reg, issue_valid_next;
    logic            issue_first_reg, issue_first_next;
    logic            issue_last_reg, issue_last_next;
    logic [AW-1:0]   issue_idx_reg;

    logic            pend_reg, pend_next, pend_set;
    logic [OUT_TDATA_W-1:0] pend_idx_reg, pend_idx_set;
    logic            pend_found_reg, pend_found_set;
    logic            pend_full_reg, pend_full_set;

    logic            out_valid_reg, out_valid_next, load_out;
    logic [OUT_TDATA_W-1:0] out_idx_reg;
    logic            out_found_reg, out_full_reg;

    logic            accept, scan_last, ram_we;
    logic [PT_W-1:0] ram_rdata;
    cmd_t            cmd;
    logic            has_outline;

    beat_t           chain_beat [NUM_AXES+1];
    logic [AW-1:0]   chain_idx [NUM_AXES+1];
    logic            sel_done;
    logic [AW-1:0]   sel_idx;
    logic [IDXW-1:0] sel_idx_wide;

    assign cmd         = cmd_t'(s_tuser);
    assign has_outline = s_tdata[OUTLINE_BIT];
    assign s_tready    = (state_reg == ST_IDLE) && !pend_reg;
    assign accept      = s_tvalid && s_tready;
    assign scan_last   = (CW'(scan_addr_reg) + CW'(1)) == count_reg;
    assign sel_idx_wide = IDXW'(sel_idx);

    // Sample table
    nfps_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[POS_LSB +: PT_W]),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // Command sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_addr_next   = scan_addr_reg;
        latch_query      = 1'b0;
        ram_we           = 1'b0;
        issue_valid_next = 1'b0;
        issue_first_next = 1'b0;
        issue_last_next  = 1'b0;
        pend_set         = 1'b0;
        pend_idx_set     = '0;
        pend_found_set   = 1'b0;
        pend_full_set    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            pend_set   = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            pend_set = 1'b1;
                            if (count_reg != CW'(MAX_SAMPLES))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                pend_full_set = 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (!has_outline)
                            begin
                                pend_set       = 1'b1;
                                pend_found_set = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                pend_set = 1'b1;
                            end
                            else
                            begin
                                latch_query    = 1'b1;
                                scan_addr_next = '0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            pend_set = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                issue_valid_next = 1'b1;
                issue_first_next = (scan_addr_reg == '0);
                issue_last_next  = scan_last;
                scan_addr_next   = scan_addr_reg + AW'(1);
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sel_done)
                begin
                    pend_set       = 1'b1;
                    pend_found_set = 1'b1;
                    pend_idx_set   = sel_idx_wide[OUT_TDATA_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pending result and output register
    assign load_out       = pend_reg && (!out_valid_reg || m_tready);
    assign pend_next      = pend_set || (pend_reg && !load_out);
    assign out_valid_next = load_out || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            issue_valid_reg <= 1'b0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            issue_valid_reg <= issue_valid_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        scan_addr_reg   <= scan_addr_next;
        issue_first_reg <= issue_first_next;
        issue_last_reg  <= issue_last_next;
        issue_idx_reg   <= scan_addr_reg;
        if (latch_query)
        begin
            center_reg <= s_tdata[POS_LSB +: PT_W];
            normal_reg <= s_tdata[NORMAL_LSB +: PT_W];
        end
        if (pend_set)
        begin
            pend_idx_reg   <= pend_idx_set;
            pend_found_reg <= pend_found_set;
            pend_full_reg  <= pend_full_set;
        end
        if (load_out)
        begin
            out_idx_reg   <= pend_idx_reg;
            out_found_reg <= pend_found_reg;
            out_full_reg  <= pend_full_reg;
        end
    end

    // Head of the cell row: RAM read data plus zero sums
    always_comb
    begin
        chain_beat[0].valid = issue_valid_reg;
        chain_beat[0].first = issue_first_reg;
        chain_beat[0].last  = issue_last_reg;
        chain_beat[0].pt    = ram_rdata;
        chain_beat[0].d2    = '0;
        chain_beat[0].dot   = '0;
    end
    assign chain_idx[0] = issue_idx_reg;

    // One cell per axis
    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_cell
        nfps_cell #(
            .IW   (AW),
            .AXIS (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (chain_beat[k]),
            .idx_in   (chain_idx[k]),
            .center   (center_reg[k]),
            .normal   (normal_reg[k]),
            .beat_out (chain_beat[k+1]),
            .idx_out  (chain_idx[k+1])
        );
    end

    nfps_select #(
        .IW (AW)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat_in (chain_beat[NUM_AXES]),
        .idx_in  (chain_idx[NUM_AXES]),
        .done    (sel_done),
        .idx     (sel_idx)
    );

    assign m_tvalid            = out_valid_reg;
    assign m_tdata             = out_idx_reg;
    assign m_tuser[FOUND_BIT]  = out_found_reg;
    assign m_tuser[FULL_BIT]   = out_full_reg;

endmodule

>>> src/nfps_ram.sv
module nfps_ram
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/nfps_cell.sv
module nfps_cell
    import nfps_pkg::*;
#(
    parameter int IW   = 8,
    parameter int AXIS = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  beat_t         beat_in,
    input  logic [IW-1:0] idx_in,
    input  coord_t        center,
    input  coord_t        normal,
    output beat_t         beat_out,
    output logic [IW-1:0] idx_out
);

    beat_t                      s1_beat_reg, s2_beat_reg, s3_beat_reg;
    beat_t                      s3_beat_next;
    logic [IW-1:0]              s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [DELTA_W-1:0]  s1_delta_reg, s1_delta_next;
    logic [SQ_W-1:0]            s2_sq_reg;
    logic signed [PROD_W-1:0]   s2_pr_reg;
    logic signed [DELTA_W-1:0]  normal_ext;
    logic signed [2*DELTA_W-1:0] sq_full, pr_full;

    // Stage 1: delta on this cell's axis
    assign s1_delta_next = DELTA_W'(beat_in.pt[AXIS]) - DELTA_W'(center);

    // Stage 2: square and normal product
    assign normal_ext = DELTA_W'(normal);
    assign sq_full    = s1_delta_reg * s1_delta_reg;
    assign pr_full    = s1_delta_reg * normal_ext;

    // Stage 3: fold into the running sums
    always_comb
    begin
        s3_beat_next     = s2_beat_reg;
        s3_beat_next.d2  = s2_beat_reg.d2 + D2_W'(s2_sq_reg);
        s3_beat_next.dot = s2_beat_reg.dot + DOT_W'(s2_pr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_beat_reg <= '0;
            s2_beat_reg <= '0;
            s3_beat_reg <= '0;
        end
        else
        begin
            s1_beat_reg <= beat_in;
            s2_beat_reg <= s1_beat_reg;
            s3_beat_reg <= s3_beat_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= idx_in;
        s1_delta_reg <= s1_delta_next;
        s2_idx_reg   <= s1_idx_reg;
        s2_sq_reg    <= sq_full[SQ_W-1:0];
        s2_pr_reg    <= pr_full[PROD_W-1:0];
        s3_idx_reg   <= s2_idx_reg;
    end

    assign beat_out = s3_beat_reg;
    assign idx_out  = s3_idx_reg;

endmodule

>>> src/nfps_select.sv
module nfps_select
    import nfps_pkg::*;
#(
    parameter int IW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  beat_t         beat_in,
    input  logic [IW-1:0] idx_in,
    output logic          done,
    output logic [IW-1:0] idx
);

    logic            have_front_reg, have_front_next;
    logic [D2_W-1:0] best_front_reg, best_front_next;
    logic [D2_W-1:0] best_any_reg, best_any_next;
    logic [IW-1:0]   idx_front_reg, idx_front_next;
    logic [IW-1:0]   idx_any_reg, idx_any_next;
    logic            facing;

    assign facing = !beat_in.dot[DOT_W-1];

    // Track best facing and best overall; strict compare keeps the lower index
    always_comb
    begin
        have_front_next = have_front_reg;
        best_front_next = best_front_reg;
        idx_front_next  = idx_front_reg;
        best_any_next   = best_any_reg;
        idx_any_next    = idx_any_reg;
        if (beat_in.valid)
        begin
            if (beat_in.first)
            begin
                have_front_next = facing;
                best_front_next = beat_in.d2;
                idx_front_next  = idx_in;
                best_any_next   = beat_in.d2;
                idx_any_next    = idx_in;
            end
            else
            begin
                if (facing && (!have_front_reg || beat_in.d2 < best_front_reg))
                begin
                    have_front_next = 1'b1;
                    best_front_next = beat_in.d2;
                    idx_front_next  = idx_in;
                end
                if (beat_in.d2 < best_any_reg)
                begin
                    best_any_next = beat_in.d2;
                    idx_any_next  = idx_in;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_front_reg <= 1'b0;
        end
        else
        begin
            have_front_reg <= have_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_front_reg <= best_front_next;
        idx_front_reg  <= idx_front_next;
        best_any_reg   <= best_any_next;
        idx_any_reg    <= idx_any_next;
    end

    assign done = beat_in.valid && beat_in.last;
    assign idx  = have_front_next ? idx_front_next : idx_any_next;

endmodule

>>> src/nfps_checker.sv
module nfps_checker
    import nfps_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic [IN_TUSER_W-1:0]  s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser
);

    // Waiting input beat stays up with its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input beat changed while waiting");

    // Stalled output beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // Stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // A dropped append never reports a found sample
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[FOUND_BIT] && m_tuser[FULL_BIT]))
        else $error("found and table_full both set");

    // No sample chosen means index zero
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[FOUND_BIT] |-> m_tdata == '0)
        else $error("nonzero index without found");

endmodule

bind nearest_facing_point_search nfps_checker u_nfps_checker (.*);
